// File: src/cc_pkg.sv
// ----------------------------------------------------------------------------
// cc_pkg: shared types and constants for the circumcenter pipeline
// Status codes, the control word passed down the divider chain, and the
// default sizes of the coordinate and fixed-point formats.
// ----------------------------------------------------------------------------
`default_nettype none

package cc_pkg;

	// Port widths of the item fields
	localparam int IN_W  = 16;
	localparam int OUT_W = 62;

	// Default sizes
	localparam int COORD_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF  = 8;

	// Result status
	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_SAME = 2'd1,
		ST_LINE = 2'd2
	} status_t;

	// Control word that travels with every item down the chain
	typedef struct packed {
		logic    valid;
		status_t status;
		logic    neg_x;
		logic    neg_y;
	} ctrl_t;

endpackage

`default_nettype wire

// File: src/cc_front.sv
// ----------------------------------------------------------------------------
// cc_front: front-end arithmetic of the circumcenter pipeline
// Five stages: differences, first products, bisector terms and determinant,
// second products, then signed numerators split into magnitude and sign.
// ----------------------------------------------------------------------------
`default_nettype none

module cc_front
	import cc_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	parameter int MW         = 3 * COORD_BITS + 3 + FRAC_BITS,
	parameter int DVW        = 2 * COORD_BITS + 2
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            in_valid,
	input  wire logic [IN_W-1:0] p1_x,
	input  wire logic [IN_W-1:0] p1_y,
	input  wire logic [IN_W-1:0] p2_x,
	input  wire logic [IN_W-1:0] p2_y,
	input  wire logic [IN_W-1:0] p3_x,
	input  wire logic [IN_W-1:0] p3_y,
	output ctrl_t                ctrl_o,
	output logic [MW-1:0]        num_x,
	output logic [MW-1:0]        num_y,
	output logic [DVW-1:0]       den
);

	localparam int CW = COORD_BITS;
	localparam int DW = CW + 1;          // differences and sums
	localparam int PW = 2 * CW + 2;      // bisector terms, determinant
	localparam int QW = PW + DW;         // second products
	localparam int NW = QW + 1;          // numerators
	localparam int SW = NW + FRAC_BITS;  // scaled numerators

	// Coordinates taken from the low COORD_BITS bits, sign-extended
	logic signed [CW-1:0] x1, y1, x2, y2, x3, y3;
	assign x1 = p1_x[CW-1:0];
	assign y1 = p1_y[CW-1:0];
	assign x2 = p2_x[CW-1:0];
	assign y2 = p2_y[CW-1:0];
	assign x3 = p3_x[CW-1:0];
	assign y3 = p3_y[CW-1:0];

	logic v_s1, v_s2, v_s3, v_s4;

	logic signed [DW-1:0] dx12_s1, dy12_s1, dx23_s1, dy23_s1;
	logic signed [DW-1:0] sx12_s1, sy12_s1, sx23_s1, sy23_s1;
	logic                 same_s1;

	logic signed [PW-1:0] mex_s2, mey_s2, mjx_s2, mjy_s2, md1_s2, md2_s2;
	logic signed [DW-1:0] dx12_s2, dy12_s2, dx23_s2, dy23_s2;
	logic                 same_s2;

	logic signed [PW-1:0] e2_s3, j2_s3, det_s3;
	logic signed [DW-1:0] dx12_s3, dy12_s3, dx23_s3, dy23_s3;
	logic                 same_s3;

	logic signed [QW-1:0] pex_s4, pey_s4, pyx_s4, pyy_s4;
	logic signed [PW-1:0] det_s4;
	status_t              st_s4;

	// Stage 5 combinational: numerators, scaling, magnitudes
	logic signed [SW-1:0] nx, ny, scx, scy, magx, magy;
	logic        [PW-1:0] dabs;

	always_comb begin
		nx   = SW'(pex_s4) - SW'(pey_s4);
		ny   = SW'(pyx_s4) - SW'(pyy_s4);
		scx  = nx <<< FRAC_BITS;
		scy  = ny <<< FRAC_BITS;
		magx = scx[SW-1] ? -scx : scx;
		magy = scy[SW-1] ? -scy : scy;
		dabs = det_s4[PW-1] ? PW'(-det_s4) : PW'(det_s4);
	end

	// Valid bits and control word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			ctrl_o <= '0;
		end else if (en) begin
			v_s1         <= in_valid;
			v_s2         <= v_s1;
			v_s3         <= v_s2;
			v_s4         <= v_s3;
			ctrl_o.valid <= v_s4;
			ctrl_o.status <= st_s4;
			ctrl_o.neg_x <= scx[SW-1] ^ det_s4[PW-1];
			ctrl_o.neg_y <= scy[SW-1] ^ det_s4[PW-1];
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (en) begin
			// stage 1: differences, sums, coincidence
			dx12_s1 <= DW'(x1) - DW'(x2);
			dy12_s1 <= DW'(y1) - DW'(y2);
			dx23_s1 <= DW'(x2) - DW'(x3);
			dy23_s1 <= DW'(y2) - DW'(y3);
			sx12_s1 <= DW'(x1) + DW'(x2);
			sy12_s1 <= DW'(y1) + DW'(y2);
			sx23_s1 <= DW'(x2) + DW'(x3);
			sy23_s1 <= DW'(y2) + DW'(y3);
			same_s1 <= (x1 == x2 && y1 == y2) || (x1 == x3 && y1 == y3) ||
				(x2 == x3 && y2 == y3);

			// stage 2: first products
			mex_s2  <= PW'(dx12_s1) * PW'(sx12_s1);
			mey_s2  <= PW'(dy12_s1) * PW'(sy12_s1);
			mjx_s2  <= PW'(dx23_s1) * PW'(sx23_s1);
			mjy_s2  <= PW'(dy23_s1) * PW'(sy23_s1);
			md1_s2  <= PW'(dx12_s1) * PW'(dy23_s1);
			md2_s2  <= PW'(dy12_s1) * PW'(dx23_s1);
			dx12_s2 <= dx12_s1;
			dy12_s2 <= dy12_s1;
			dx23_s2 <= dx23_s1;
			dy23_s2 <= dy23_s1;
			same_s2 <= same_s1;

			// stage 3: bisector terms and determinant
			e2_s3   <= mex_s2 + mey_s2;
			j2_s3   <= mjx_s2 + mjy_s2;
			det_s3  <= md1_s2 - md2_s2;
			dx12_s3 <= dx12_s2;
			dy12_s3 <= dy12_s2;
			dx23_s3 <= dx23_s2;
			dy23_s3 <= dy23_s2;
			same_s3 <= same_s2;

			// stage 4: second products, status
			pex_s4 <= QW'(e2_s3) * QW'(dy23_s3);
			pey_s4 <= QW'(dy12_s3) * QW'(j2_s3);
			pyx_s4 <= QW'(dx12_s3) * QW'(j2_s3);
			pyy_s4 <= QW'(e2_s3) * QW'(dx23_s3);
			det_s4 <= det_s3;
			st_s4  <= same_s3 ? ST_SAME : ((det_s3 == '0) ? ST_LINE : ST_OK);

			// stage 5: magnitudes for the divider, divisor is 2*|det|
			num_x <= magx[MW-1:0];
			num_y <= magy[MW-1:0];
			den   <= DVW'({dabs[PW-2:0], 1'b0});
		end
	end

endmodule

`default_nettype wire

// File: src/cc_cell.sv
// ----------------------------------------------------------------------------
// cc_cell: one restoring-division step for both centre coordinates
// Shifts one numerator bit into each partial remainder, subtracts the
// divisor where it fits, and shifts the quotient bit in from the right.
// ----------------------------------------------------------------------------
`default_nettype none

module cc_cell
	import cc_pkg::*;
#(
	parameter int MW  = 59,
	parameter int DVW = 34
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire ctrl_t          ctrl_i,
	input  wire logic [DVW-1:0] den_i,
	input  wire logic [MW-1:0]  qx_i,
	input  wire logic [DVW-1:0] rx_i,
	input  wire logic [MW-1:0]  qy_i,
	input  wire logic [DVW-1:0] ry_i,
	output ctrl_t               ctrl_o,
	output logic [DVW-1:0]      den_o,
	output logic [MW-1:0]       qx_o,
	output logic [DVW-1:0]      rx_o,
	output logic [MW-1:0]       qy_o,
	output logic [DVW-1:0]      ry_o
);

	logic [DVW:0]   tx, ty, dext;
	logic           gex, gey;
	logic [DVW-1:0] rx_n, ry_n;

	// Trial subtraction on both lanes
	always_comb begin
		dext = {1'b0, den_i};
		tx   = {rx_i, qx_i[MW-1]};
		ty   = {ry_i, qy_i[MW-1]};
		gex  = (tx >= dext);
		gey  = (ty >= dext);
		rx_n = gex ? DVW'(tx - dext) : DVW'(tx);
		ry_n = gey ? DVW'(ty - dext) : DVW'(ty);
	end

	// Control word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_o <= '0;
		end else if (en) begin
			ctrl_o <= ctrl_i;
		end
	end

	// Remainders and quotient bits
	always_ff @(posedge clk) begin
		if (en) begin
			den_o <= den_i;
			rx_o  <= rx_n;
			ry_o  <= ry_n;
			qx_o  <= {qx_i[MW-2:0], gex};
			qy_o  <= {qy_i[MW-2:0], gey};
		end
	end

endmodule

`default_nettype wire

// File: src/circumcenter_of_three_points.sv
// An accepted item passes the five front-end stages, the MW division cells
// and the output register, where MW = 3*COORD_BITS + 3 + FRAC_BITS.
// Throughput: one item per cycle while not stalled; the divider is a row of
// MW cells, one quotient bit per cell, fed by five arithmetic stages.
// The pipeline holds only while the output register and the last cell are
// both occupied and out_ready is low. Reset clears all valid bits.
// ----------------------------------------------------------------------------
// circumcenter_of_three_points: circle centre through three points
// Cramer's rule in a five-stage front end, a chain of restoring-division
// cells for both coordinates, and a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module circumcenter_of_three_points
	import cc_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [IN_W-1:0]    p1_x,
	input  wire logic [IN_W-1:0]    p1_y,
	input  wire logic [IN_W-1:0]    p2_x,
	input  wire logic [IN_W-1:0]    p2_y,
	input  wire logic [IN_W-1:0]    p3_x,
	input  wire logic [IN_W-1:0]    p3_y,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [OUT_W-1:0] center_x,
	output logic signed [OUT_W-1:0] center_y,
	output logic [1:0]              status
);

	localparam int MW  = 3 * COORD_BITS + 3 + FRAC_BITS;  // quotient magnitude
	localparam int DVW = 2 * COORD_BITS + 2;              // divisor magnitude

	ctrl_t          ch_ctrl [0:MW];
	logic [DVW-1:0] ch_den  [0:MW];
	logic [DVW-1:0] ch_rx   [0:MW];
	logic [DVW-1:0] ch_ry   [0:MW];
	logic [MW-1:0]  ch_qx   [0:MW];
	logic [MW-1:0]  ch_qy   [0:MW];

	logic en;

	// Advance unless a finished item would overrun a held output
	assign en       = !(ch_ctrl[MW].valid && out_valid && !out_ready);
	assign in_ready = en;

	cc_front #(
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS (FRAC_BITS),
		.MW        (MW),
		.DVW       (DVW)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_valid(in_valid),
		.p1_x    (p1_x),
		.p1_y    (p1_y),
		.p2_x    (p2_x),
		.p2_y    (p2_y),
		.p3_x    (p3_x),
		.p3_y    (p3_y),
		.ctrl_o  (ch_ctrl[0]),
		.num_x   (ch_qx[0]),
		.num_y   (ch_qy[0]),
		.den     (ch_den[0])
	);

	assign ch_rx[0] = '0;
	assign ch_ry[0] = '0;

	// Division chain
	for (genvar i = 0; i < MW; i++) begin : g_cell
		cc_cell #(
			.MW (MW),
			.DVW(DVW)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.ctrl_i(ch_ctrl[i]),
			.den_i (ch_den[i]),
			.qx_i  (ch_qx[i]),
			.rx_i  (ch_rx[i]),
			.qy_i  (ch_qy[i]),
			.ry_i  (ch_ry[i]),
			.ctrl_o(ch_ctrl[i+1]),
			.den_o (ch_den[i+1]),
			.qx_o  (ch_qx[i+1]),
			.rx_o  (ch_rx[i+1]),
			.qy_o  (ch_qy[i+1]),
			.ry_o  (ch_ry[i+1])
		);
	end

	// Signed quotients, zero unless a centre was found
	logic [OUT_W-1:0] mag_x, mag_y, res_x, res_y;
	logic             found;

	always_comb begin
		found = (ch_ctrl[MW].status == ST_OK);
		mag_x = OUT_W'(ch_qx[MW]);
		mag_y = OUT_W'(ch_qy[MW]);
		res_x = '0;
		res_y = '0;
		if (found) begin
			res_x = ch_ctrl[MW].neg_x ? -mag_x : mag_x;
			res_y = ch_ctrl[MW].neg_y ? -mag_y : mag_y;
		end
	end

	// Output register
	logic             out_valid_q;
	logic [OUT_W-1:0] center_x_q, center_y_q;
	status_t          status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en && ch_ctrl[MW].valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en && ch_ctrl[MW].valid) begin
			center_x_q <= res_x;
			center_y_q <= res_y;
			status_q   <= ch_ctrl[MW].status;
		end
	end

	assign out_valid = out_valid_q;
	assign center_x  = center_x_q;
	assign center_y  = center_y_q;
	assign status    = status_q;

endmodule

`default_nettype wire

// File: bench/circumcenter_of_three_points_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circumcenter_of_three_points_test: self-checking bench for the circle centre
// A directed set and then random point triples go into the block. An
// independent integer model predicts each centre and its status, and the
// monitor checks every result in order. Idling on both sides changes from
// phase to phase, and a long output hold-off fills the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module circumcenter_of_three_points_test;
	import cc_pkg::*;

	localparam int COORD_W    = COORD_BITS_DEF;
	localparam int FRAC_W     = FRAC_BITS_DEF;
	localparam int DRAIN_WAIT = 3 * COORD_W + 3 + FRAC_W + 16;
	localparam int HOLD_LEN   = 400;
	localparam int STALL_MAX  = 5000;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	typedef struct {
		logic [IN_W-1:0] x1, y1, x2, y2, x3, y3;
	} triple_t;

	typedef struct {
		logic [OUT_W-1:0] cx;
		logic [OUT_W-1:0] cy;
		status_t          st;
	} center_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [IN_W-1:0] p1_x = '0, p1_y = '0, p2_x = '0, p2_y = '0, p3_x = '0, p3_y = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [OUT_W-1:0] center_x, center_y;
	logic [1:0] status;

	triple_t    pending_triples[$];
	center_t    expected_centers[$];
	triple_t    offered;
	idle_mode_t idle_mode = IDLE_NONE;
	int         mismatch_count = 0;
	int         hold_requests = 0;
	int         hold_served = 0;
	int         hold_left = 0;
	int         quiet_cycles = 0;

	circumcenter_of_three_points dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.p1_x      (p1_x),
		.p1_y      (p1_y),
		.p2_x      (p2_x),
		.p2_y      (p2_y),
		.p3_x      (p3_x),
		.p3_y      (p3_y),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.center_x  (center_x),
		.center_y  (center_y),
		.status    (status)
	);

	always #1 clk = ~clk;

	// Centre by Cramer's rule in exact 64-bit arithmetic
	function automatic center_t predict_center(input triple_t t);
		longint x1, y1, x2, y2, x3, y3;
		longint dx12, dy12, dx23, dy23, e2, j2, det, nx, ny, qx, qy;
		center_t c;
		x1 = longint'($signed(t.x1[COORD_W-1:0]));
		y1 = longint'($signed(t.y1[COORD_W-1:0]));
		x2 = longint'($signed(t.x2[COORD_W-1:0]));
		y2 = longint'($signed(t.y2[COORD_W-1:0]));
		x3 = longint'($signed(t.x3[COORD_W-1:0]));
		y3 = longint'($signed(t.y3[COORD_W-1:0]));
		c.cx = '0;
		c.cy = '0;
		c.st = ST_OK;
		if ((x1 == x2 && y1 == y2) || (x1 == x3 && y1 == y3) || (x2 == x3 && y2 == y3)) begin
			c.st = ST_SAME;
			return c;
		end
		dx12 = x1 - x2;
		dy12 = y1 - y2;
		dx23 = x2 - x3;
		dy23 = y2 - y3;
		e2 = dx12 * (x1 + x2) + dy12 * (y1 + y2);
		j2 = dx23 * (x2 + x3) + dy23 * (y2 + y3);
		det = dx12 * dy23 - dy12 * dx23;
		if (det == 0) begin
			c.st = ST_LINE;
			return c;
		end
		nx = (e2 * dy23 - dy12 * j2) * (longint'(1) << FRAC_W);
		ny = (dx12 * j2 - e2 * dx23) * (longint'(1) << FRAC_W);
		// signed division truncates toward zero
		qx = nx / (2 * det);
		qy = ny / (2 * det);
		c.cx = qx[OUT_W-1:0];
		c.cy = qy[OUT_W-1:0];
		return c;
	endfunction

	task automatic queue_triple(input int ax, input int ay, input int bx, input int by,
			input int qx, input int qy);
		triple_t t;
		t.x1 = ax[IN_W-1:0];
		t.y1 = ay[IN_W-1:0];
		t.x2 = bx[IN_W-1:0];
		t.y2 = by[IN_W-1:0];
		t.x3 = qx[IN_W-1:0];
		t.y3 = qy[IN_W-1:0];
		pending_triples.push_back(t);
	endtask

	// Full-range coordinate, biased toward the corners
	function automatic int rand_coord();
		case ($urandom_range(15))
			0: return -32768;
			1: return 32767;
			2: return 0;
			3: return -1;
			default: return int'($urandom_range(65535)) - 32768;
		endcase
	endfunction

	// Random triple: general, tight cluster, collinear or with a repeated point
	task automatic queue_random_triple();
		int kind;
		int c[6];
		int bx, by, dx, dy, k, m;
		kind = $urandom_range(99);
		for (int i = 0; i < 6; i++)
			c[i] = rand_coord();
		if (kind >= 60 && kind < 72) begin
			for (int i = 0; i < 6; i++)
				c[i] = int'($urandom_range(12)) - 6;
		end else if (kind >= 72 && kind < 86) begin
			bx = int'($urandom_range(2000)) - 1000;
			by = int'($urandom_range(2000)) - 1000;
			dx = int'($urandom_range(60)) - 30;
			dy = int'($urandom_range(60)) - 30;
			k = int'($urandom_range(60)) - 30;
			m = int'($urandom_range(60)) - 30;
			c[0] = bx;
			c[1] = by;
			c[2] = bx + k * dx;
			c[3] = by + k * dy;
			c[4] = bx + m * dx;
			c[5] = by + m * dy;
		end else if (kind >= 86) begin
			case ($urandom_range(2))
				0: begin c[2] = c[0]; c[3] = c[1]; end
				1: begin c[4] = c[0]; c[5] = c[1]; end
				default: begin c[4] = c[2]; c[5] = c[3]; end
			endcase
		end
		queue_triple(c[0], c[1], c[2], c[3], c[4], c[5]);
	endtask

	function automatic bit sender_pause();
		case (idle_mode)
			IDLE_SENDER: return $urandom_range(99) < 79;
			IDLE_BOTH:   return $urandom_range(99) < 7;
			default:     return 1'b0;
		endcase
	endfunction

	function automatic bit receiver_pause();
		case (idle_mode)
			IDLE_RECEIVER: return $urandom_range(99) < 79;
			IDLE_BOTH:     return $urandom_range(99) < 7;
			default:       return 1'b0;
		endcase
	endfunction

	// Input driver: predict on accept, then offer the next item or idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				expected_centers.push_back(predict_center(offered));
			if (!in_valid || in_ready) begin
				if (pending_triples.size() != 0 && !sender_pause()) begin
					offered = pending_triples.pop_front();
					p1_x <= offered.x1;
					p1_y <= offered.y1;
					p2_x <= offered.x2;
					p2_y <= offered.y2;
					p3_x <= offered.x3;
					p3_y <= offered.y3;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: check against the oldest prediction, then pick ready
	always @(posedge clk or negedge arst_n) begin
		center_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_centers.size() == 0) begin
					$error("result with no item outstanding: center_x %0d center_y %0d status %0d",
						center_x, center_y, status);
					mismatch_count++;
				end else begin
					want = expected_centers.pop_front();
					if (center_x !== want.cx) begin
						$error("center_x: expected %0d, got %0d", $signed(want.cx), center_x);
						mismatch_count++;
					end
					if (center_y !== want.cy) begin
						$error("center_y: expected %0d, got %0d", $signed(want.cy), center_y);
						mismatch_count++;
					end
					if (status !== want.st) begin
						$error("status: expected %0d, got %0d", want.st, status);
						mismatch_count++;
					end
				end
			end
			// long hold-off on request, else random stalls
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (hold_requests != hold_served) begin
				hold_served++;
				hold_left = HOLD_LEN - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= !receiver_pause();
			end
		end
	end

	// Watchdog on cycles with no item moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_MAX) begin
				$display("circumcenter_of_three_points test failed");
				$finish;
			end
		end
	end

	task automatic wait_inputs_taken();
		while (pending_triples.size() != 0 || in_valid)
			@(posedge clk);
	endtask

	task automatic run_random_phase(input idle_mode_t mode, input int count);
		idle_mode = mode;
		for (int i = 0; i < count; i++)
			queue_random_triple();
		wait_inputs_taken();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: corners, repeated points, collinear sets, huge and tiny centres
		idle_mode = IDLE_NONE;
		queue_triple(0, 0, 1, 0, 0, 1);
		queue_triple(-32768, -32768, 32767, -32768, -32768, 32767);
		queue_triple(32767, 32767, -32768, 32767, 32767, -32768);
		queue_triple(-32768, 32767, 32767, 32767, 32767, -32768);
		queue_triple(-32768, -32768, 32767, 32767, 32767, 32766);
		queue_triple(-32768, -32768, -32767, -32768, 32767, 32767);
		queue_triple(5, 7, 5, 7, -3, 2);
		queue_triple(5, 7, -3, 2, 5, 7);
		queue_triple(-3, 2, 5, 7, 5, 7);
		queue_triple(-32768, -32768, -32768, -32768, -32768, -32768);
		queue_triple(32767, 32767, 32767, 32767, 32767, 32767);
		queue_triple(5, 7, 5, 8, 5, 9);
		queue_triple(5, 7, 5, -8, 5, 9);
		queue_triple(-32768, 3, 0, 3, 32767, 3);
		queue_triple(-32768, -32768, 0, 0, 32767, 32767);
		queue_triple(-32768, 32767, 0, -1, 32767, -32768);
		queue_triple(1, 2, 3, 4, 7, 8);
		queue_triple(0, 0, 32767, 0, 0, -32768);
		queue_triple(-1, -1, 1, -1, 0, 1);
		queue_triple(0, 0, 2, 0, 1, 1);
		queue_triple(100, -200, -300, 400, 700, 900);
		queue_triple(-32768, 0, 32767, 0, 0, 32767);
		queue_triple(-32768, 0, 32767, 0, 0, 1);
		wait_inputs_taken();

		run_random_phase(IDLE_NONE, 400);
		run_random_phase(IDLE_SENDER, 400);
		run_random_phase(IDLE_RECEIVER, 400);
		run_random_phase(IDLE_BOTH, 400);

		// Output held off while the sender keeps offering
		idle_mode = IDLE_NONE;
		hold_requests++;
		run_random_phase(IDLE_NONE, 150);

		while (expected_centers.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatch_count == 0 && expected_centers.size() == 0)
			$display("circumcenter_of_three_points test passed");
		else
			$display("circumcenter_of_three_points test failed");
		$finish;
	end

endmodule

`default_nettype wire
